// File: hdl/spps_pkg.sv
// Package for the stacked periodic pulse sum block.
// Holds widths, counts and the channel entry type; no dependencies.
package spps_pkg;
    localparam int CHANNELS  = 8;
    localparam int IDX_BITS  = 3;
    localparam int TIME_BITS = 32;
    localparam int PER_BITS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int HGT_BITS  = 16;
    localparam int VAL_BITS  = 19;
    localparam int CNT_BITS  = 4;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_MIN      = 2'd1;
    localparam logic [1:0] REG_MAX      = 2'd2;

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic [PER_BITS-1:0]        period;
        logic [FRAC_BITS-1:0]       start;
        logic [FRAC_BITS-1:0]       width;
        logic signed [HGT_BITS-1:0] height;
    } entry_t;

    // Token moving down the chain: the evaluation time and the running sum.
    typedef struct packed {
        logic                       valid;
        logic [TIME_BITS-1:0]       t;
        logic signed [VAL_BITS+2:0] sum;
    } token_t;

    localparam int SUM_BITS = VAL_BITS + 3;
endpackage

// File: hdl/stacked_periodic_pulse_sum.sv
// Top level of the stacked periodic pulse sum block.
// Uses spps_pkg and a row of spps_cell instances.
//
// Usage: s_ beats carry either a channel entry write (mode 1, no result)
// or an evaluate request (mode 0) at time s_time_req. Each evaluation
// yields one m_value beat: the sum of heights of the first channels_in_use
// channels whose window holds the time's phase, clamped to min/max.
// A token walks the chain of eight cells; each enabled cell with a nonzero
// period takes the token, reduces the time mod period, works out the phase
// fraction and adds its height; a skipped cell passes the token straight
// on. The result register loads in the cycle after the last cell hands
// the token on, and m_valid rises with it. One item is in flight at a
// time: s_ready stays low from the accepted evaluate beat until its
// result is taken. A write does not drop s_ready.
// While the receiver stalls, the block holds the result and accepts no
// new beat.
// Reset (aresetn low, synchronous) clears the table to zero,
// channels_in_use to 0 and the bounds to their full range.
// The user must write configuration through cfg_we/cfg_index/cfg_data only when idle; the block does not enforce it.
module stacked_periodic_pulse_sum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [18:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_time_req,
    input  logic [2:0]  s_channel_index,
    input  logic [31:0] s_period,
    input  logic [15:0] s_start_phase,
    input  logic [15:0] s_width_fraction,
    input  logic signed [15:0] s_height,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [18:0] m_value
);
    localparam int N = spps_pkg::CHANNELS;

    logic [spps_pkg::CNT_BITS-1:0] chan_reg;
    logic signed [spps_pkg::VAL_BITS-1:0] min_reg, max_reg;
    logic busy_reg, busy_next;
    logic m_valid_reg, m_valid_next;
    logic signed [spps_pkg::VAL_BITS-1:0] value_reg, value_next;
    spps_pkg::token_t chain [N+1];
    spps_pkg::entry_t wr_entry;
    logic signed [spps_pkg::SUM_BITS-1:0] s1;
    logic accept;

    assign s_ready = !busy_reg && !m_valid_reg;
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= '0;
            min_reg  <= -19'sd262144;
            max_reg  <= 19'sd262143;
        end else if (cfg_we) begin
            case (cfg_index)
                spps_pkg::REG_CHANNELS: chan_reg <= cfg_data[spps_pkg::CNT_BITS-1:0];
                spps_pkg::REG_MIN:      min_reg <= cfg_data;
                spps_pkg::REG_MAX:      max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign wr_entry = '{period: s_period, start: s_start_phase,
                        width: s_width_fraction, height: s_height};

    always_comb begin
        chain[0].valid = accept && s_mode == spps_pkg::MODE_EVAL;
        chain[0].t     = s_time_req;
        chain[0].sum   = '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        spps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (accept && s_mode == spps_pkg::MODE_WRITE
                       && s_channel_index == spps_pkg::IDX_BITS'(i)),
            .wr_entry (wr_entry),
            .enabled  ({1'b0, chan_reg} > 5'(i)),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        value_next   = value_reg;
        s1 = chain[N].sum;
        if (s1 < spps_pkg::SUM_BITS'(min_reg)) s1 = spps_pkg::SUM_BITS'(min_reg);
        if (s1 > spps_pkg::SUM_BITS'(max_reg)) s1 = spps_pkg::SUM_BITS'(max_reg);
        if (chain[0].valid) busy_next = 1'b1;
        if (chain[N].valid) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            value_next   = s1[spps_pkg::VAL_BITS-1:0];
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg <= value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = value_reg;
endmodule

// File: hdl/spps_cell.sv
// One channel cell: holds one table entry, takes the token from its left
// neighbor, divides bit-serially for the phase and adds its height if the
// phase is in its window. Depends on spps_pkg.
module spps_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  spps_pkg::entry_t      wr_entry,
    input  logic                  enabled,
    input  spps_pkg::token_t      tok_in,
    output spps_pkg::token_t      tok_out
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_FRAC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    spps_pkg::entry_t entry_reg;
    spps_pkg::token_t tok_reg, tok_next;
    logic [1:0]  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [spps_pkg::PER_BITS:0]    rem_reg, rem_next;
    logic [spps_pkg::TIME_BITS-1:0] dvd_reg, dvd_next;
    logic [spps_pkg::FRAC_BITS-1:0] q_reg, q_next;
    logic [spps_pkg::PER_BITS:0]    trial;
    logic [spps_pkg::PER_BITS:0]    shifted;
    logic [spps_pkg::FRAC_BITS:0]   off;
    logic                           hit;
    logic signed [spps_pkg::SUM_BITS-1:0] h_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else if (wr_en) begin
            entry_reg <= wr_entry;
        end
    end

    always_comb begin
        shifted = state_reg == ST_MOD
                ? {rem_reg[spps_pkg::PER_BITS-1:0], dvd_reg[spps_pkg::TIME_BITS-1]}
                : {rem_reg[spps_pkg::PER_BITS-1:0], 1'b0};
        trial = shifted - {1'b0, entry_reg.period};
        off = {1'b0, entry_reg.start} + {1'b0, entry_reg.width};
        if (!off[spps_pkg::FRAC_BITS])
            hit = q_reg > entry_reg.start && q_reg < off[spps_pkg::FRAC_BITS-1:0];
        else
            hit = q_reg < off[spps_pkg::FRAC_BITS-1:0] || q_reg > entry_reg.start;
        h_ext = spps_pkg::SUM_BITS'(entry_reg.height);

        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        q_next     = q_reg;
        tok_next   = tok_reg;
        tok_next.valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (tok_in.valid) begin
                    tok_next.t   = tok_in.t;
                    tok_next.sum = tok_in.sum;
                    rem_next = '0;
                    dvd_next = tok_in.t;
                    step_next = '0;
                    if (!enabled || entry_reg.period == '0) begin
                        tok_next.valid = 1'b1;
                    end else begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                // restoring division, one dividend bit a cycle
                rem_next = trial[spps_pkg::PER_BITS] ? shifted : trial;
                dvd_next = {dvd_reg[spps_pkg::TIME_BITS-2:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(spps_pkg::TIME_BITS-1)) begin
                    step_next = '0;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                rem_next = trial[spps_pkg::PER_BITS] ? shifted : trial;
                q_next = {q_reg[spps_pkg::FRAC_BITS-2:0], ~trial[spps_pkg::PER_BITS]};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(spps_pkg::FRAC_BITS-1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (hit) tok_next.sum = tok_reg.sum + h_ext;
                tok_next.valid = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tok_reg.valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.t   <= tok_next.t;
        tok_reg.sum <= tok_next.sum;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
    end

    assign tok_out = tok_reg;
endmodule
